@@ src/btffa_pkg.sv @@
// Package for the boundary-tag first-fit allocator.
// Pool geometry, beat and tag types, command codes. No dependencies.
package btffa_pkg;

  localparam int POOL_BYTES = 1024;
  localparam int TAG_BYTES  = 8;

  // Address width of the tag store, and a wider width for offset sums.
  localparam int AW = $clog2(POOL_BYTES);
  localparam int XW = AW + 2;
  // Chunk sizes never exceed POOL_BYTES - 2*TAG_BYTES.
  localparam int SW = AW;

  localparam logic [XW-1:0] X_POOL  = XW'(POOL_BYTES);
  localparam logic [XW-1:0] X_TAG   = XW'(TAG_BYTES);
  localparam logic [XW-1:0] X_TAG2  = XW'(2 * TAG_BYTES);
  localparam logic [XW-1:0] X_MAXSZ = XW'(POOL_BYTES - 2 * TAG_BYTES);
  localparam logic [SW-1:0] INIT_SZ = SW'(POOL_BYTES - 2 * TAG_BYTES);
  localparam logic [AW:0]   END_TAG = (AW + 1)'(POOL_BYTES - TAG_BYTES);
  localparam logic [AW:0]   CLR_LAST = (AW + 1)'(POOL_BYTES - 1);

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [10:0] req_size;
    logic [9:0]  handle;
  } in_beat_t;

  typedef struct packed {
    logic [9:0] chunk_offset;
    logic       ok;
  } out_beat_t;

  typedef struct packed {
    logic          fr;
    logic [SW-1:0] size;
  } tag_t;

endpackage

@@ src/boundary_tag_first_fit_allocator_unit.sv @@
// Top level of the boundary-tag first-fit allocator.
// Uses btffa_pkg; holds the tag store memory and the command sequencer.

// One beat in gives one beat out. After reset, and on every init command, a
// clearing pass writes all 1024 tag entries, one a cycle, with the input
// stalled; init then answers ok. Allocate walks the chunk chain from offset
// zero, one tag read per chunk, then writes back tags on success and posts
// the result. Free takes up to three tag reads (own header, left footer,
// right header) and then writes back tags. The tag store has a single read
// port and a single write port. The result sits in an output register, so the
// next command is taken while an earlier result still waits on out_stall.
module boundary_tag_first_fit_allocator_unit
  import btffa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLR  = 3'd1;
  localparam logic [2:0] ST_AW   = 3'd2;  // alloc walk: evaluate header
  localparam logic [2:0] ST_FHD  = 3'd3;  // free: own header
  localparam logic [2:0] ST_FLF  = 3'd4;  // free: left footer
  localparam logic [2:0] ST_FRH  = 3'd5;  // free: right header
  localparam logic [2:0] ST_WR   = 3'd6;  // tag write-back
  localparam logic [2:0] ST_RESP = 3'd7;

  // Tag store
  tag_t mem [POOL_BYTES];
  tag_t rd_q;
  logic          we_c;
  logic [XW-1:0] wa_c;
  tag_t          wd_c;
  logic [XW-1:0] ra_c;

  always_ff @(posedge clk) begin
    if (we_c && (wa_c < X_POOL)) mem[wa_c[AW-1:0]] <= wd_c;
    rd_q <= mem[ra_c[AW-1:0]];
  end

  logic [2:0]    state_r, state_nxt;
  logic [AW:0]   clr_r, clr_nxt;
  logic          init_r, init_nxt;     // clearing pass owes an init result
  logic [1:0]    op_r, op_nxt;
  logic [XW-1:0] s_r, s_nxt;           // alloc offset / free handle
  logic [XW-1:0] req_r, req_nxt;
  logic [SW-1:0] hsz_r, hsz_nxt;       // size of chosen / freed chunk
  logic          split_r, split_nxt;
  logic [XW-1:0] nx_r, nx_nxt;
  logic          lm_r, lm_nxt;
  logic [XW-1:0] ph_r, ph_nxt;
  logic [SW-1:0] szl_r, szl_nxt;
  logic          rm_r, rm_nxt;
  logic [XW-1:0] nf_r, nf_nxt;
  logic [SW-1:0] szr_r, szr_nxt;
  logic [2:0]    ws_r, ws_nxt;
  out_beat_t     res_r, res_nxt;
  logic          ov_r, ov_nxt;
  out_beat_t     od_r, od_nxt;

  logic [XW-1:0] hs_c, ft_c, hdcur_c, s_step_c, hd_c, nx_c;
  logic [SW-1:0] rem_c, szcur_c;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  assign hs_c     = XW'(rd_q.size);
  assign ft_c     = s_r + X_TAG + XW'(hsz_r);
  assign hdcur_c  = lm_r ? ph_r : s_r;
  assign szcur_c  = lm_r ? szl_r : hsz_r;
  assign rem_c    = SW'(XW'(hsz_r) - req_r - X_TAG2);
  assign s_step_c = s_r + hs_c + X_TAG2;
  assign hd_c     = XW'(in_data.handle);
  assign nx_c     = s_r + X_TAG2 + hs_c;

  // Write-back port
  always_comb begin
    we_c = 1'b0;
    wa_c = '0;
    wd_c = '0;
    if (state_r == ST_CLR) begin
      we_c = 1'b1;
      wa_c = XW'(clr_r);
      if (clr_r == '0 || clr_r == END_TAG) wd_c = '{fr: 1'b1, size: INIT_SZ};
    end else if (state_r == ST_WR) begin
      if (op_r == CMD_ALLOC) begin
        case (ws_r)
          3'd0: begin
            we_c = 1'b1; wa_c = s_r;
            wd_c = '{fr: 1'b0, size: split_r ? SW'(req_r) : hsz_r};
          end
          3'd1: begin
            we_c = 1'b1;
            wa_c = split_r ? s_r + X_TAG + req_r : ft_c;
            wd_c = '{fr: 1'b0, size: split_r ? SW'(req_r) : hsz_r};
          end
          3'd2: begin
            we_c = split_r; wa_c = s_r + X_TAG2 + req_r;
            wd_c = '{fr: 1'b1, size: rem_c};
          end
          3'd3: begin
            we_c = split_r; wa_c = ft_c;
            wd_c = '{fr: 1'b1, size: rem_c};
          end
          default: we_c = 1'b0;
        endcase
      end else begin
        case (ws_r)
          3'd0: begin we_c = 1'b1; wa_c = s_r;  wd_c = '{fr: 1'b1, size: hsz_r}; end
          3'd1: begin we_c = 1'b1; wa_c = ft_c; wd_c = '{fr: 1'b1, size: hsz_r}; end
          3'd2: begin we_c = lm_r; wa_c = ph_r; wd_c = '{fr: 1'b1, size: szl_r}; end
          3'd3: begin we_c = lm_r; wa_c = ft_c; wd_c = '{fr: 1'b1, size: szl_r}; end
          3'd4: begin we_c = rm_r; wa_c = nf_r; wd_c = '{fr: 1'b1, size: szr_r}; end
          3'd5: begin we_c = rm_r; wa_c = hdcur_c; wd_c = '{fr: 1'b1, size: szr_r}; end
          default: we_c = 1'b0;
        endcase
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;  clr_nxt = clr_r;     init_nxt = init_r;
    op_nxt    = op_r;     s_nxt   = s_r;       req_nxt  = req_r;
    hsz_nxt   = hsz_r;    split_nxt = split_r; nx_nxt   = nx_r;
    lm_nxt    = lm_r;     ph_nxt  = ph_r;      szl_nxt  = szl_r;
    rm_nxt    = rm_r;     nf_nxt  = nf_r;      szr_nxt  = szr_r;
    ws_nxt    = ws_r;     res_nxt = res_r;
    ov_nxt    = ov_r;     od_nxt  = od_r;
    ra_c      = '0;

    if (ov_r && !out_stall) ov_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_data.cmd;
          req_nxt = XW'(in_data.req_size);
          lm_nxt  = 1'b0;
          rm_nxt  = 1'b0;
          ws_nxt  = '0;
          res_nxt = '0;
          case (in_data.cmd)
            CMD_INIT: begin
              clr_nxt = '0; init_nxt = 1'b1; state_nxt = ST_CLR;
            end
            CMD_ALLOC: begin
              s_nxt = '0; ra_c = '0; state_nxt = ST_AW;
            end
            CMD_FREE: begin
              s_nxt = hd_c;
              if (hd_c + X_TAG2 > X_POOL) begin
                state_nxt = ST_RESP;
              end else begin
                ra_c = hd_c; state_nxt = ST_FHD;
              end
            end
            default: state_nxt = ST_RESP;
          endcase
        end
      end
      ST_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CLR_LAST) begin
          if (init_r) begin
            res_nxt = '{chunk_offset: '0, ok: 1'b1};
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_IDLE;
          end
          init_nxt = 1'b0;
        end
      end
      ST_AW: begin
        if (hs_c > X_MAXSZ - s_r) begin
          state_nxt = ST_RESP;
        end else if (rd_q.fr && hs_c >= req_r) begin
          hsz_nxt   = rd_q.size;
          split_nxt = (hs_c - req_r) >= X_TAG2;
          res_nxt   = '{chunk_offset: s_r[9:0], ok: 1'b1};
          state_nxt = ST_WR;
        end else begin
          s_nxt = s_step_c;
          if (s_step_c + X_TAG2 <= X_POOL) ra_c = s_step_c;
          else state_nxt = ST_RESP;
        end
      end
      ST_FHD: begin
        if (hs_c > X_MAXSZ - s_r || rd_q.fr) begin
          state_nxt = ST_RESP;
        end else begin
          res_nxt = '{chunk_offset: '0, ok: 1'b1};
          hsz_nxt = rd_q.size;
          nx_nxt  = nx_c;
          if (s_r >= X_TAG2) begin
            ra_c = s_r - X_TAG; state_nxt = ST_FLF;
          end else if (nx_c + X_TAG2 <= X_POOL) begin
            ra_c = nx_c; state_nxt = ST_FRH;
          end else begin
            state_nxt = ST_WR;
          end
        end
      end
      ST_FLF: begin
        if (rd_q.fr && hs_c <= s_r - X_TAG2) begin
          lm_nxt  = 1'b1;
          ph_nxt  = s_r - X_TAG2 - hs_c;
          szl_nxt = SW'(hs_c + X_TAG2 + XW'(hsz_r));
        end
        if (nx_r + X_TAG2 <= X_POOL) begin
          ra_c = nx_r; state_nxt = ST_FRH;
        end else begin
          state_nxt = ST_WR;
        end
      end
      ST_FRH: begin
        if (rd_q.fr && hs_c <= X_MAXSZ - nx_r) begin
          rm_nxt  = 1'b1;
          nf_nxt  = nx_r + X_TAG + hs_c;
          szr_nxt = SW'(hs_c + X_TAG2 + XW'(szcur_c));
        end
        state_nxt = ST_WR;
      end
      ST_WR: begin
        ws_nxt = ws_r + 1'b1;
        if (ws_r == 3'd5) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          od_nxt = res_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r   <= '0;
      init_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      init_r  <= init_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;   s_r <= s_nxt;     req_r <= req_nxt;
    hsz_r <= hsz_nxt; split_r <= split_nxt; nx_r <= nx_nxt;
    lm_r <= lm_nxt;   ph_r <= ph_nxt;   szl_r <= szl_nxt;
    rm_r <= rm_nxt;   nf_r <= nf_nxt;   szr_r <= szr_nxt;
    ws_r <= ws_nxt;   res_r <= res_nxt; od_r <= od_nxt;
  end

endmodule

@@ src/btffa_checker.sv @@
// Port-level checker for the allocator, bound to the top level.
// Uses btffa_pkg.
module btffa_checker
  import btffa_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  // Reset starts the clearing pass with no result pending.
  a_reset: assert property (@(posedge clk) !rst_n |=> in_stall && !out_valid)
    else $error("reset did not stall input");

  // One command at a time.
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while busy");

  // A failed command reports offset zero.
  a_fail0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.chunk_offset == '0)
    else $error("failed result with nonzero offset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind boundary_tag_first_fit_allocator_unit btffa_checker u_btffa_checker (.*);
